// File: src/cpu6809_pkg.sv
// Shared types and codes for the 6809 register and ALU unit.
package cpu6809_pkg;
  typedef enum logic [4:0] {
    K_LD = 5'd0, K_ST = 5'd1, K_LEA = 5'd2, K_CLR = 5'd3, K_INC = 5'd4, K_DEC = 5'd5,
    K_BIT = 5'd6, K_CMP = 5'd7, K_TST = 5'd8, K_AND = 5'd9, K_OR = 5'd10, K_EOR = 5'd11,
    K_COM = 5'd12, K_NEG = 5'd13, K_ANDCC = 5'd14, K_ORCC = 5'd15, K_TFR = 5'd16,
    K_EXG = 5'd17
  } kind_t;
  localparam logic [2:0] T_A = 3'd0, T_B = 3'd1, T_D = 3'd2, T_X = 3'd3, T_Y = 3'd4,
                         T_U = 3'd5, T_S = 3'd6, T_MEM = 3'd7;
  localparam logic [3:0] R_D = 4'd0, R_X = 4'd1, R_Y = 4'd2, R_U = 4'd3, R_S = 4'd4,
                         R_PC = 4'd5, R_A = 4'd8, R_B = 4'd9, R_CC = 4'd10, R_DP = 4'd11;
  localparam logic [7:0] CC_RESET = 8'h50;
  localparam int CC_C = 0, CC_V = 1, CC_Z = 2, CC_N = 3;
  typedef struct packed {
    logic [7:0]  a, b, dp, cc;
    logic [15:0] x, y, u, s;
  } regs_t;
  typedef struct packed {
    logic        mem_write, mem_wide;
    logic [15:0] mem_address, mem_data;
    logic [7:0]  cc_out;
    logic        pc_write;
    logic [15:0] pc_new;
  } res_t;
endpackage

// File: src/cpu6809_exec.sv
// Combinational execute logic: one operation against the register file.
module cpu6809_exec (
  input  cpu6809_pkg::regs_t  regs_i,
  input  logic [4:0]          kind,
  input  logic [2:0]          target,
  input  logic [15:0]         operand,
  input  logic [15:0]         address,
  input  logic [15:0]         pc_value,
  output cpu6809_pkg::regs_t  regs_o,
  output cpu6809_pkg::res_t   res
);
  import cpu6809_pkg::*;

  logic        wide, byte_ok;
  logic [15:0] tv, wv, xs, xd, m16, o16, d16;
  logic [7:0]  s8, r8;
  logic        wr_tgt, st_byte, sb;
  logic [16:0] diff;

  function automatic logic [15:0] xr_rd(input regs_t g, input logic [3:0] c,
                                        input logic [15:0] pc);
    case (c)
      R_D:  xr_rd = {g.a, g.b};
      R_X:  xr_rd = g.x;
      R_Y:  xr_rd = g.y;
      R_U:  xr_rd = g.u;
      R_S:  xr_rd = g.s;
      R_PC: xr_rd = pc;
      R_A:  xr_rd = {8'h00, g.a};
      R_B:  xr_rd = {8'h00, g.b};
      R_CC: xr_rd = {8'h00, g.cc};
      R_DP: xr_rd = {8'h00, g.dp};
      default: xr_rd = 16'h0000;
    endcase
  endfunction

  function automatic regs_t xr_wr(input regs_t g, input logic [3:0] c,
                                  input logic [15:0] v);
    regs_t n;
    n = g;
    case (c)
      R_D:  {n.a, n.b} = v;
      R_X:  n.x = v;
      R_Y:  n.y = v;
      R_U:  n.u = v;
      R_S:  n.s = v;
      R_A:  n.a = v[7:0];
      R_B:  n.b = v[7:0];
      R_CC: n.cc = v[7:0];
      R_DP: n.dp = v[7:0];
      default: ;
    endcase
    return n;
  endfunction

  function automatic regs_t tg_wr(input regs_t g, input logic [2:0] t,
                                  input logic [15:0] v);
    regs_t n;
    n = g;
    case (t)
      T_A: n.a = v[7:0];
      T_B: n.b = v[7:0];
      T_D: {n.a, n.b} = v;
      T_X: n.x = v;
      T_Y: n.y = v;
      T_U: n.u = v;
      T_S: n.s = v;
      default: ;
    endcase
    return n;
  endfunction

  always_comb begin
    wide    = (target >= T_D) && (target <= T_S);
    byte_ok = (target == T_A) || (target == T_B) || (target == T_MEM);
    case (target)
      T_A: tv = {8'h00, regs_i.a};
      T_B: tv = {8'h00, regs_i.b};
      T_D: tv = {regs_i.a, regs_i.b};
      T_X: tv = regs_i.x;
      T_Y: tv = regs_i.y;
      T_U: tv = regs_i.u;
      T_S: tv = regs_i.s;
      default: tv = 16'h0000;
    endcase
    regs_o = regs_i;
    res = '0;
    wv = 16'h0000;
    wr_tgt = 1'b0;
    st_byte = 1'b1;
    s8 = (target == T_MEM) ? operand[7:0] : tv[7:0];
    r8 = s8;
    m16 = wide ? 16'hFFFF : 16'h00FF;
    o16 = operand & m16;
    diff = {1'b0, tv} - {1'b0, o16};
    d16 = diff[15:0] & m16;
    sb = 1'b0;
    xs = xr_rd(regs_i, operand[7:4], pc_value);
    xd = xr_rd(regs_i, operand[3:0], pc_value);
    case (kind)
      K_LD: if (target != T_MEM) begin
        wv = wide ? operand : {8'h00, operand[7:0]};
        regs_o = tg_wr(regs_i, target, wv);
        regs_o.cc[CC_N] = wide ? wv[15] : wv[7];
        regs_o.cc[CC_Z] = (wv == 16'h0000);
        regs_o.cc[CC_V] = 1'b0;
      end
      K_ST: if (target != T_MEM) begin
        regs_o.cc[CC_N] = wide ? tv[15] : tv[7];
        regs_o.cc[CC_Z] = (tv == 16'h0000);
        regs_o.cc[CC_V] = 1'b0;
        res.mem_write = 1'b1; res.mem_wide = wide;
        res.mem_address = address; res.mem_data = tv;
      end
      K_LEA: if (target >= T_X && target <= T_S) begin
        regs_o = tg_wr(regs_i, target, address);
        if (target == T_X || target == T_Y) regs_o.cc[CC_Z] = (address == 16'h0000);
      end
      K_CLR, K_INC, K_DEC, K_TST, K_COM, K_NEG: if (byte_ok) begin
        case (kind)
          K_CLR: begin r8 = 8'h00; regs_o.cc[CC_V] = 1'b0; regs_o.cc[CC_C] = 1'b0; end
          K_INC: begin r8 = s8 + 8'h01; regs_o.cc[CC_V] = (s8 == 8'h7F); end
          K_DEC: begin r8 = s8 - 8'h01; regs_o.cc[CC_V] = (s8 == 8'h80); end
          K_TST: begin st_byte = 1'b0; regs_o.cc[CC_V] = 1'b0; end
          K_COM: begin r8 = ~s8; regs_o.cc[CC_V] = 1'b0; regs_o.cc[CC_C] = 1'b1; end
          default: begin
            r8 = 8'h00 - s8;
            regs_o.cc[CC_V] = (s8 == 8'h80);
            regs_o.cc[CC_C] = (s8 != 8'h00);
          end
        endcase
        regs_o.cc[CC_N] = r8[7];
        regs_o.cc[CC_Z] = (r8 == 8'h00);
        if (st_byte) begin
          if (target == T_MEM) begin
            res.mem_write = 1'b1; res.mem_address = address; res.mem_data = {8'h00, r8};
          end else begin
            wr_tgt = 1'b1;
          end
        end
      end
      K_BIT, K_AND, K_OR, K_EOR: if (target == T_A || target == T_B) begin
        case (kind)
          K_OR:  r8 = tv[7:0] | operand[7:0];
          K_EOR: r8 = tv[7:0] ^ operand[7:0];
          default: r8 = tv[7:0] & operand[7:0];
        endcase
        if (kind != K_BIT) wr_tgt = 1'b1;
        regs_o.cc[CC_N] = r8[7];
        regs_o.cc[CC_Z] = (r8 == 8'h00);
        regs_o.cc[CC_V] = 1'b0;
      end
      K_CMP: if (target != T_MEM) begin
        sb = wide ? ((tv[15] ^ o16[15]) & (tv[15] ^ d16[15]))
                  : ((tv[7] ^ o16[7]) & (tv[7] ^ d16[7]));
        regs_o.cc[CC_N] = wide ? d16[15] : d16[7];
        regs_o.cc[CC_Z] = (d16 == 16'h0000);
        regs_o.cc[CC_V] = sb;
        regs_o.cc[CC_C] = diff[16];
      end
      K_ANDCC: regs_o.cc = regs_i.cc & operand[7:0];
      K_ORCC:  regs_o.cc = regs_i.cc | operand[7:0];
      K_TFR, K_EXG: begin
        if (kind == K_EXG) begin
          regs_o = xr_wr(regs_i, operand[7:4], xd);
          if (operand[7:4] == R_PC) begin res.pc_write = 1'b1; res.pc_new = xd; end
        end
        regs_o = xr_wr(regs_o, operand[3:0], xs);
        if (operand[3:0] == R_PC) begin res.pc_write = 1'b1; res.pc_new = xs; end
      end
      default: ;
    endcase
    if (wr_tgt) begin
      if (target == T_A) regs_o.a = r8;
      else regs_o.b = r8;
    end
    res.cc_out = regs_o.cc;
  end
endmodule

// File: src/cpu6809_alu_register_unit.sv
// Top level of the 6809 register and ALU unit: register file, input and result registers.
//
//  channel | transaction              | tdata fields (low bit first)
//  in_     | one decoded operation    | kind[4:0] target[7:5] operand[23:8] address[39:24]
//          |                          | pc_value[55:40]
//  out_    | one result per operation | mem_write[0] mem_wide[1] mem_address[17:2]
//          |                          | mem_data[33:18] cc_out[41:34] pc_write[42]
//          |                          | pc_new[58:43], zero pad to 64
//
// Throughput: one transaction per clock while out_tready holds. The item is registered, executed in one
// combinational pass against the register file, and the result registered.
// The input is captured in id_r, then the result in res_r, which drives out_tdata;
// out_tvalid rises when res_r is loaded.
// Reset (rst_n low, synchronous): registers zero, CC = 0x50, both stages empty.
// Stalls: input stage advances whenever the result stage is empty or drained.
module cpu6809_alu_register_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // kind, target, operand, address, pc_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // mem_write, mem_wide, mem_address, mem_data,
                                  // cc_out, pc_write, pc_new
);
  import cpu6809_pkg::*;

  logic        iv_r;
  logic [55:0] id_r;
  logic        ov_r;
  res_t        res_r, res_nxt;
  regs_t       regs_r, regs_nxt;
  logic        adv;

  // Input stage moves to result stage when result slot free.
  assign adv       = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || adv;

  cpu6809_exec u_exec (
    .regs_i   (regs_r),
    .kind     (id_r[4:0]),
    .target   (id_r[7:5]),
    .operand  (id_r[23:8]),
    .address  (id_r[39:24]),
    .pc_value (id_r[55:40]),
    .regs_o   (regs_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
      regs_r <= '{a: 8'h00, b: 8'h00, dp: 8'h00, cc: CC_RESET,
                  x: 16'h0000, y: 16'h0000, u: 16'h0000, s: 16'h0000};
    end else begin
      if (in_tready) begin
        iv_r <= in_tvalid;
        id_r <= in_tdata;
      end
      if (adv) begin
        regs_r <= regs_nxt;
        res_r  <= res_nxt;
        ov_r   <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'b00000, res_r.pc_new, res_r.pc_write, res_r.cc_out,
                       res_r.mem_data, res_r.mem_address, res_r.mem_wide,
                       res_r.mem_write};
endmodule
